>>> rtl/lav_pkg.sv
`default_nettype none
// Shared constants and request/result types for the look-at view matrix block.
package lav_pkg;

  localparam int FRAC_BITS_DEF = 16;
  // normalised magnitudes have their leading one at bit NORM_MW-1
  localparam int NORM_MW       = 30;
  localparam int WORD_W        = 32;

  localparam logic [3:0] WORD_TRANS = 4'd12;
  localparam logic [3:0] WORD_LAST  = 4'd15;

  typedef struct packed {
    logic signed [WORD_W-1:0] eye_x;
    logic signed [WORD_W-1:0] eye_y;
    logic signed [WORD_W-1:0] eye_z;
    logic signed [WORD_W-1:0] target_x;
    logic signed [WORD_W-1:0] target_y;
    logic signed [WORD_W-1:0] target_z;
    logic signed [WORD_W-1:0] up_x;
    logic signed [WORD_W-1:0] up_y;
    logic signed [WORD_W-1:0] up_z;
  } lav_in_t;

  typedef struct packed {
    logic [3:0]               element_index;
    logic signed [WORD_W-1:0] matrix_value;
    logic                     last_word;
  } lav_out_t;

endpackage
`default_nettype wire

>>> rtl/lav_if.sv
`default_nettype none
// Valid/ready channel interfaces for camera requests and matrix words.
interface lav_in_if;
  logic              valid;
  logic              ready;
  lav_pkg::lav_in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lav_out_if;
  logic              valid;
  logic              ready;
  lav_pkg::lav_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/lav_norm.sv
`default_nettype none
// Pipelined 3-vector normaliser: scale, square, bitwise root, bitwise divide.
module lav_norm #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
  parameter int IN_W      = 33,
  parameter int SIDE_W    = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [2:0][IN_W-1:0]      in_vec,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [2:0][FRAC_BITS+1:0] out_vec,
  output logic [SIDE_W-1:0]         out_side
);
  localparam int MW    = lav_pkg::NORM_MW;
  localparam int PW    = $clog2(IN_W);
  localparam int SQW   = 2 * MW;
  localparam int SUMW  = SQW + 2;
  localparam int STEPS = SUMW / 2;
  localparam int LENW  = MW + 2;
  localparam int QW    = FRAC_BITS + 2;
  localparam int DVW   = FRAC_BITS + LENW + 1;

  typedef struct packed {
    logic [SIDE_W-1:0]    side;
    logic                 zero;
    logic [2:0]           neg;
    logic [2:0][MW-1:0]   mag;
  } carry_t;

  // stage 1: magnitudes
  logic [2:0][IN_W-1:0] mag_c;
  logic                 s1_v_r;
  logic [2:0][IN_W-1:0] s1_mag_r;
  logic [2:0]           s1_neg_r;
  logic [SIDE_W-1:0]    s1_side_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = in_vec[i][IN_W-1] ? (~in_vec[i] + IN_W'(1)) : in_vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_r  <= mag_c;
      s1_side_r <= in_side;
      for (int i = 0; i < 3; i++) s1_neg_r[i] <= in_vec[i][IN_W-1];
    end
  end

  // stage 2: leading-one position of the largest magnitude
  logic [IN_W-1:0]      orv_c;
  logic [PW-1:0]        msb_c;
  logic                 s2_v_r;
  logic [PW-1:0]        s2_p_r;
  logic                 s2_zero_r;
  logic [2:0][IN_W-1:0] s2_mag_r;
  logic [2:0]           s2_neg_r;
  logic [SIDE_W-1:0]    s2_side_r;

  always_comb begin
    orv_c = s1_mag_r[0] | s1_mag_r[1] | s1_mag_r[2];
    msb_c = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (orv_c[b]) msb_c = PW'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p_r    <= msb_c;
      s2_zero_r <= (orv_c == '0);
      s2_mag_r  <= s1_mag_r;
      s2_neg_r  <= s1_neg_r;
      s2_side_r <= s1_side_r;
    end
  end

  // stage 3: common shift, leading one lands on bit MW-1 (right shift truncates)
  logic [2:0][IN_W-1:0] sh_c;
  carry_t               c3_c;
  logic                 s3_v_r;
  carry_t               c3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s2_p_r >= PW'(MW - 1)) begin
        sh_c[i] = s2_mag_r[i] >> (s2_p_r - PW'(MW - 1));
      end else begin
        sh_c[i] = s2_mag_r[i] << (PW'(MW - 1) - s2_p_r);
      end
      c3_c.mag[i] = sh_c[i][MW-1:0];
    end
    c3_c.neg  = s2_neg_r;
    c3_c.zero = s2_zero_r;
    c3_c.side = s2_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) c3_r <= c3_c;
  end

  // stage 4: squares
  logic                 s4_v_r;
  logic [2:0][SQW-1:0]  sq_r;
  carry_t               c4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_r[i] <= SQW'(c3_r.mag[i]) * SQW'(c3_r.mag[i]);
      c4_r <= c3_r;
    end
  end

  // stage 5 and root stages: one result bit per stage
  logic [SUMW-1:0] rn_r [0:STEPS];
  logic [SUMW:0]   rr_r [0:STEPS];
  carry_t          rc_r [0:STEPS];
  logic            rv_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r[0] <= 1'b0;
    end else if (en) begin
      rv_r[0] <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rn_r[0] <= SUMW'(sq_r[0]) + SUMW'(sq_r[1]) + SUMW'(sq_r[2]);
      rr_r[0] <= '0;
      rc_r[0] <= c4_r;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_root
    localparam logic [SUMW:0] RBIT = (SUMW + 1)'(1) << (2 * (STEPS - 1 - k));
    logic [SUMW:0] trial;
    assign trial = rr_r[k] + RBIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[k+1] <= 1'b0;
      end else if (en) begin
        rv_r[k+1] <= rv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rc_r[k+1] <= rc_r[k];
        if ({1'b0, rn_r[k]} >= trial) begin
          rn_r[k+1] <= rn_r[k] - trial[SUMW-1:0];
          rr_r[k+1] <= (rr_r[k] >> 1) + RBIT;
        end else begin
          rn_r[k+1] <= rn_r[k];
          rr_r[k+1] <= rr_r[k] >> 1;
        end
      end
    end
  end

  // divide prep and restoring divide, one quotient bit per stage
  logic [2:0][DVW-1:0] dn_r [0:QW];
  logic [LENW-1:0]     dl_r [0:QW];
  logic [2:0][QW-1:0]  dq_r [0:QW];
  carry_t              dc_r [0:QW];
  logic                dv_r [0:QW];
  logic [LENW-1:0]     len_c;

  assign len_c = rr_r[STEPS][LENW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= rv_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dn_r[0][i] <= DVW'({rc_r[STEPS].mag[i], {FRAC_BITS{1'b0}}}) + DVW'(len_c >> 1);
      end
      dl_r[0] <= len_c;
      dq_r[0] <= '0;
      dc_r[0] <= rc_r[STEPS];
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [DVW-1:0] dsub;
    assign dsub = DVW'(dl_r[j]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dl_r[j+1] <= dl_r[j];
        dc_r[j+1] <= dc_r[j];
        for (int i = 0; i < 3; i++) begin
          if (dn_r[j][i] >= dsub) begin
            dn_r[j+1][i] <= dn_r[j][i] - dsub;
            dq_r[j+1][i] <= dq_r[j][i] | (QW'(1) << SH);
          end else begin
            dn_r[j+1][i] <= dn_r[j][i];
            dq_r[j+1][i] <= dq_r[j][i];
          end
        end
      end
    end
  end

  // sign and zero-length handling
  logic                out_v_r;
  logic [2:0][QW-1:0]  out_vec_r;
  logic [SIDE_W-1:0]   out_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side_r <= dc_r[QW].side;
      for (int i = 0; i < 3; i++) begin
        if (dc_r[QW].zero) begin
          out_vec_r[i] <= '0;
        end else if (dc_r[QW].neg[i]) begin
          out_vec_r[i] <= ~dq_r[QW][i] + QW'(1);
        end else begin
          out_vec_r[i] <= dq_r[QW][i];
        end
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_vec   = out_vec_r;
  assign out_side  = out_side_r;

endmodule
`default_nettype wire

>>> rtl/lav_cross.sv
`default_nettype none
// Two-stage cross product of unit vectors: products, then differences.
module lav_cross #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
  parameter int OUT_W     = 33,
  parameter int SIDE_W    = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [2:0][FRAC_BITS+1:0] a,
  input  logic [2:0][FRAC_BITS+1:0] b,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [2:0][OUT_W-1:0]     r,
  output logic [SIDE_W-1:0]         out_side
);
  localparam int PRW = 2 * (FRAC_BITS + 2);

  logic                  p_v_r;
  logic [5:0][PRW-1:0]   p_r;
  logic [SIDE_W-1:0]     p_side_r;
  logic                  r_v_r;
  logic [2:0][OUT_W-1:0] r_r;
  logic [SIDE_W-1:0]     r_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      r_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= in_valid;
      r_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]   <= PRW'($signed(a[1]) * $signed(b[2]));
      p_r[1]   <= PRW'($signed(a[2]) * $signed(b[1]));
      p_r[2]   <= PRW'($signed(a[2]) * $signed(b[0]));
      p_r[3]   <= PRW'($signed(a[0]) * $signed(b[2]));
      p_r[4]   <= PRW'($signed(a[0]) * $signed(b[1]));
      p_r[5]   <= PRW'($signed(a[1]) * $signed(b[0]));
      p_side_r <= in_side;
      for (int i = 0; i < 3; i++) begin
        // true difference fits OUT_W, so modulo arithmetic is exact
        r_r[i] <= OUT_W'($signed(p_r[2*i])) - OUT_W'($signed(p_r[2*i+1]));
      end
      r_side_r <= p_side_r;
    end
  end

  assign out_valid = r_v_r;
  assign r         = r_r;
  assign out_side  = r_side_r;

endmodule
`default_nettype wire

>>> rtl/look_at_view_matrix.sv
`default_nettype none
// Top level of the look-at view matrix generator.
// Each request carries eye, target and up vectors (signed fixed point, FRAC_BITS
// fraction bits) and yields sixteen result words: the column-major view matrix
// in index order, last_word set on word 15. Z = norm(eye - target), X = norm(norm(up) x Z),
// Y = norm(Z x X); a zero-length vector normalises to zero, and words 12 to 14
// (-X.eye, -Y.eye, -Z.eye, rounded) saturate to the 32-bit range. The datapath is
// a fully pipelined chain that takes a request every cycle unless held; its latency to the
// first word is set by three normalisers in series, each a bit-per-stage square root
// and divider. The sixteen words leave one per cycle, while out_ch.ready is high,
// through the single result channel. A request is taken while an earlier matrix
// is still being sent; when the word buffer is full and the last pipeline stage is
// occupied the whole pipeline holds, losing nothing.
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  lav_in_if.sink           in_ch,
  lav_out_if.source        out_ch
);
  localparam int WW  = lav_pkg::WORD_W;
  localparam int UW  = FRAC_BITS + 2;                  // unit component width
  localparam int NW  = (2 * FRAC_BITS + 3 > WW + 1) ? 2 * FRAC_BITS + 3 : WW + 1;
  localparam int PDW = UW + WW;                        // dot product term
  localparam int SW  = UW + WW + 4;                    // dot sum with headroom

  typedef logic [2:0][WW-1:0] vec_t;
  typedef logic [2:0][UW-1:0] unit_t;

  typedef struct packed {
    vec_t  eye;
    unit_t az;
  } side2_t;

  typedef struct packed {
    vec_t  eye;
    unit_t az;
    unit_t ax;
  } side3_t;

  logic en;        // global advance: all stages move together
  logic load;      // finished matrix moves into the word buffer

  // input register: difference and up widened to normaliser width
  logic                 v0_r;
  vec_t                 eye0_r;
  logic [2:0][NW-1:0]   dir0_r;
  logic [2:0][NW-1:0]   up0_r;
  vec_t                 eye_c;
  vec_t                 tgt_c;
  vec_t                 up_c;

  assign eye_c = {in_ch.data.eye_z, in_ch.data.eye_y, in_ch.data.eye_x};
  assign tgt_c = {in_ch.data.target_z, in_ch.data.target_y, in_ch.data.target_x};
  assign up_c  = {in_ch.data.up_z, in_ch.data.up_y, in_ch.data.up_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye0_r <= eye_c;
      for (int i = 0; i < 3; i++) begin
        dir0_r[i] <= NW'($signed(eye_c[i])) - NW'($signed(tgt_c[i]));
        up0_r[i]  <= NW'($signed(up_c[i]));
      end
    end
  end

  // Z and Y0 in parallel normalisers of equal latency
  logic  n1_v;
  unit_t az1;
  vec_t  eye1;
  unit_t y0;

  lav_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(NW), .SIDE_W($bits(vec_t))) u_norm_z (
    .clk, .rst_n, .en,
    .in_valid (v0_r),
    .in_vec   (dir0_r),
    .in_side  (eye0_r),
    .out_valid(n1_v),
    .out_vec  (az1),
    .out_side (eye1)
  );

  lav_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(NW), .SIDE_W(1)) u_norm_up (
    .clk, .rst_n, .en,
    .in_valid (v0_r),
    .in_vec   (up0_r),
    .in_side  (1'b0),
    .out_valid(),
    .out_vec  (y0),
    .out_side ()
  );

  // X = norm(Y0 x Z)
  side2_t             c1_side_in;
  side2_t             c1_side;
  logic               c1_v;
  logic [2:0][NW-1:0] c1_r;
  logic               n3_v;
  unit_t              ax3;
  side2_t             n3_side;

  assign c1_side_in.eye = eye1;
  assign c1_side_in.az  = az1;

  lav_cross #(.FRAC_BITS(FRAC_BITS), .OUT_W(NW), .SIDE_W($bits(side2_t))) u_cross_x (
    .clk, .rst_n, .en,
    .in_valid (n1_v),
    .a        (y0),
    .b        (az1),
    .in_side  (c1_side_in),
    .out_valid(c1_v),
    .r        (c1_r),
    .out_side (c1_side)
  );

  lav_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(NW), .SIDE_W($bits(side2_t))) u_norm_x (
    .clk, .rst_n, .en,
    .in_valid (c1_v),
    .in_vec   (c1_r),
    .in_side  (c1_side),
    .out_valid(n3_v),
    .out_vec  (ax3),
    .out_side (n3_side)
  );

  // Y = norm(Z x X)
  side3_t             c2_side_in;
  side3_t             c2_side;
  logic               c2_v;
  logic [2:0][NW-1:0] c2_r;
  logic               n4_v;
  unit_t              ay4;
  side3_t             n4_side;

  assign c2_side_in.eye = n3_side.eye;
  assign c2_side_in.az  = n3_side.az;
  assign c2_side_in.ax  = ax3;

  lav_cross #(.FRAC_BITS(FRAC_BITS), .OUT_W(NW), .SIDE_W($bits(side3_t))) u_cross_y (
    .clk, .rst_n, .en,
    .in_valid (n3_v),
    .a        (n3_side.az),
    .b        (ax3),
    .in_side  (c2_side_in),
    .out_valid(c2_v),
    .r        (c2_r),
    .out_side (c2_side)
  );

  lav_norm #(.FRAC_BITS(FRAC_BITS), .IN_W(NW), .SIDE_W($bits(side3_t))) u_norm_y (
    .clk, .rst_n, .en,
    .in_valid (c2_v),
    .in_vec   (c2_r),
    .in_side  (c2_side),
    .out_valid(n4_v),
    .out_vec  (ay4),
    .out_side (n4_side)
  );

  // translation words: products, sums, then negate, round and saturate
  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] WMAX = SW'({1'b0, {(WW-1){1'b1}}});
  localparam logic signed [SW-1:0] WMIN = -WMAX - SW'(1);

  logic                       d1_v_r;
  logic [2:0][2:0][PDW-1:0]   d1_p_r;     // [axis][component]
  unit_t                      d1_ax_r, d1_ay_r, d1_az_r;
  logic                       d2_v_r;
  logic [2:0][SW-1:0]         d2_s_r;
  unit_t                      d2_ax_r, d2_ay_r, d2_az_r;
  logic                       d3_v_r;
  logic [2:0][WW-1:0]         d3_t_r;
  unit_t                      d3_ax_r, d3_ay_r, d3_az_r;
  logic signed [SW-1:0]       rnd_c [3];
  logic signed [SW-1:0]       q_c   [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
      d3_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= n4_v;
      d2_v_r <= d1_v_r;
      d3_v_r <= d2_v_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd_c[k] = HALF - $signed(d2_s_r[k]);
      q_c[k]   = rnd_c[k] >>> FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_p_r[0][i] <= PDW'($signed(n4_side.ax[i]) * $signed(n4_side.eye[i]));
        d1_p_r[1][i] <= PDW'($signed(ay4[i]) * $signed(n4_side.eye[i]));
        d1_p_r[2][i] <= PDW'($signed(n4_side.az[i]) * $signed(n4_side.eye[i]));
      end
      d1_ax_r <= n4_side.ax;
      d1_ay_r <= ay4;
      d1_az_r <= n4_side.az;

      for (int k = 0; k < 3; k++) begin
        d2_s_r[k] <= SW'($signed(d1_p_r[k][0])) + SW'($signed(d1_p_r[k][1]))
                   + SW'($signed(d1_p_r[k][2]));
      end
      d2_ax_r <= d1_ax_r;
      d2_ay_r <= d1_ay_r;
      d2_az_r <= d1_az_r;

      for (int k = 0; k < 3; k++) begin
        if (q_c[k] > WMAX) begin
          d3_t_r[k] <= WMAX[WW-1:0];
        end else if (q_c[k] < WMIN) begin
          d3_t_r[k] <= WMIN[WW-1:0];
        end else begin
          d3_t_r[k] <= q_c[k][WW-1:0];
        end
      end
      d3_ax_r <= d2_ax_r;
      d3_ay_r <= d2_ay_r;
      d3_az_r <= d2_az_r;
    end
  end

  // word buffer: one matrix, sent a word per cycle while out_ch.ready is high
  logic               busy_r;
  logic [3:0]         cnt_r;
  unit_t              ax_r, ay_r, az_r;
  logic [2:0][WW-1:0] tw_r;
  logic [WW-1:0]      word_c;
  logic [1:0]         col_c;

  assign load = d3_v_r && (!busy_r || (out_ch.ready && cnt_r == lav_pkg::WORD_LAST));
  assign en   = !d3_v_r || load;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r && out_ch.ready) begin
      if (cnt_r == lav_pkg::WORD_LAST) busy_r <= 1'b0;
      cnt_r <= cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ax_r <= d3_ax_r;
      ay_r <= d3_ay_r;
      az_r <= d3_az_r;
      tw_r <= d3_t_r;
    end
  end

  always_comb begin
    col_c  = cnt_r[3:2];
    word_c = '0;
    if (cnt_r == lav_pkg::WORD_LAST) begin
      word_c = WW'(1) << FRAC_BITS;
    end else if (cnt_r >= lav_pkg::WORD_TRANS) begin
      word_c = tw_r[cnt_r[1:0]];
    end else begin
      case (cnt_r[1:0])
        2'd0:    word_c = WW'($signed(ax_r[col_c]));
        2'd1:    word_c = WW'($signed(ay_r[col_c]));
        2'd2:    word_c = WW'($signed(az_r[col_c]));
        default: word_c = '0;
      endcase
    end
  end

  assign out_ch.valid              = busy_r;
  assign out_ch.data.element_index = cnt_r;
  assign out_ch.data.matrix_value  = word_c;
  assign out_ch.data.last_word     = (cnt_r == lav_pkg::WORD_LAST);

  // checks
  a_wrap_to_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && cnt_r == lav_pkg::WORD_LAST)
      |=> (!out_ch.valid || cnt_r == 4'd0))
    else $error("matrix did not restart at word 0");

  a_word_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && cnt_r != lav_pkg::WORD_LAST)
      |=> (out_ch.valid && cnt_r == $past(cnt_r) + 4'd1))
    else $error("word index skipped or repeated");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> (d3_v_r && $stable(d3_t_r)))
    else $error("final stage changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (d3_v_r && busy_r))
    else $error("request refused without a full pipeline");

endmodule
`default_nettype wire
